/* sv/sliding_window_maximum_core_macros.svh */
// ---------------------------------------------------------------------------
// sliding window maximum assertion macros
// shared concurrent assertion forms, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SWM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SWM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/swm_pkg.sv */
// ---------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window maximum core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  // width and reset value of the window length register
  localparam int unsigned WIN_REG_W = 7;
  localparam logic [WIN_REG_W-1:0] WIN_RESET = 7'd5;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // a sample transaction is taken this cycle
    logic shift;  // oldest candidate leaves the window, chain moves toward cell 0
    logic flush;  // restart: drop all candidates before the new sample
    logic clear;  // window length written: drop all candidates
  } cell_ctrl_t;

endpackage

/* sv/sliding_window_maximum_core.sv */
// ---------------------------------------------------------------------------
// sliding_window_maximum_core
// running maximum over the last window_size signed samples
// ---------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------
//   in       | in_valid / in_stall    | sample, restart
//   out      | out_valid / out_stall  | window_max
//   cfg      | cfg_valid / cfg_ready  | window_size
//
// one sample transaction per cycle while in_stall is low: every cell compares
// its candidate with the new sample in parallel, chain shifts at most one slot
// a result leaves through one output register the cycle after its sample
// rst (synchronous) empties the chain, zeroes position and fill count and sets
// the window length to 5; a window_size write does the same but for the length
// in_stall is high only while the output register holds a result that is
// being stalled; a result taken in the same cycle lets the next sample in
// no results until win_eff samples of the current sequence have arrived
`timescale 1ns / 1ps
`include "sliding_window_maximum_core_macros.svh"

module sliding_window_maximum_core #(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       window_max,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swm_pkg::WIN_REG_W-1:0]        window_size
);
  import swm_pkg::*;

  // positions wrap modulo a power of two at least twice the window
  localparam int unsigned POS_W = $clog2(MAX_WINDOW) + 1;
  // common width for window, age and fill compares
  localparam int unsigned CW    = (POS_W > WIN_REG_W) ? POS_W : WIN_REG_W;
  localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WINDOW);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // window length register and sequence counters
  logic [WIN_REG_W-1:0] win_reg;
  logic [POS_W-1:0]     position;
  logic [CW-1:0]        filled;

  logic [CW-1:0]        win_ext;
  logic [CW-1:0]        win_eff;
  logic [POS_W-1:0]     cur_pos;
  logic [POS_W-1:0]     age;
  logic [CW-1:0]        fill_cur;
  logic [CW-1:0]        filled_next;
  logic                 accept;
  logic                 cfg_write;
  logic                 retire;
  logic                 emit;
  cell_ctrl_t           ctrl;

  // chain wiring
  logic [MAX_WINDOW-1:0]   cell_keep;
  logic [MAX_WINDOW-1:0]   cell_occ;
  logic [MAX_WINDOW-1:0]   cell_valid;
  logic [SAMPLE_WIDTH-1:0] cell_value      [MAX_WINDOW];
  logic [POS_W-1:0]        cell_pos        [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] cell_value_next [MAX_WINDOW];

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;

  // zero acts as one, anything above the cell count saturates
  assign win_ext = CW'(win_reg);
  always_comb begin
    if (win_ext == '0) begin
      win_eff = ONE_C;
    end else if (win_ext > MAX_W_C) begin
      win_eff = MAX_W_C;
    end else begin
      win_eff = win_ext;
    end
  end

  // a restart sample is the first of a fresh sequence
  assign cur_pos  = restart ? '0 : position;
  assign fill_cur = restart ? '0 : filled;

  // at most one candidate can age out per sample, and only the oldest
  assign age    = cur_pos - cell_pos[0];
  assign retire = cell_valid[0] && !restart && (CW'(age) >= win_eff);

  assign filled_next = (fill_cur < win_eff) ? fill_cur + ONE_C : fill_cur;
  assign emit        = filled_next >= win_eff;

  assign ctrl.load  = accept;
  assign ctrl.shift = accept && retire;
  assign ctrl.flush = restart;
  assign ctrl.clear = cfg_write;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                    left_occ;
    logic                    right_keep;
    logic [SAMPLE_WIDTH-1:0] right_value;
    logic [POS_W-1:0]        right_pos;

    if (i == 0) begin : g_head
      assign left_occ = 1'b1;
    end else begin : g_body
      assign left_occ = cell_occ[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign right_keep  = 1'b0;
      assign right_value = cell_value[i];
      assign right_pos   = cell_pos[i];
    end else begin : g_link
      assign right_keep  = cell_keep[i+1];
      assign right_value = cell_value[i+1];
      assign right_pos   = cell_pos[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .POS_W       (POS_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample     (sample),
      .sample_pos (cur_pos),
      .left_occ   (left_occ),
      .right_keep (right_keep),
      .right_value(right_value),
      .right_pos  (right_pos),
      .keep       (cell_keep[i]),
      .occ        (cell_occ[i]),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .pos        (cell_pos[i]),
      .value_next (cell_value_next[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg  <= WIN_RESET;
      position <= '0;
      filled   <= '0;
    end else if (cfg_write) begin
      win_reg  <= window_size;
      position <= '0;
      filled   <= '0;
    end else if (accept) begin
      position <= cur_pos + 1'b1;
      filled   <= filled_next;
    end
  end

  // output register: the oldest candidate after the update is the maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      window_max <= $signed(cell_value_next[0]);
    end
  end

  // occupied slots always form a prefix of the chain
  `SWM_ASSERT_IMPL(a_valid_prefix, clk, rst, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
  // once any sample of the sequence is in, the head slot holds a candidate
  `SWM_ASSERT_IMPL(a_head_valid, clk, rst, filled != '0, cell_valid[0])
  // an emitting sample always lands in the output register
  `SWM_ASSERT_NEXT(a_emit_lands, clk, rst, accept && emit, out_valid)
  // fill count never passes the window length
  `SWM_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, filled <= win_eff)

endmodule

/* sv/swm_cell.sv */
// ---------------------------------------------------------------------------
// swm_cell
// one candidate slot of the monotonic list
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned POS_W        = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  swm_pkg::cell_ctrl_t     ctrl,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [POS_W-1:0]        sample_pos,
  input  logic                    left_occ,    // slot to the left stays occupied
  input  logic                    right_keep,
  input  logic [SAMPLE_WIDTH-1:0] right_value,
  input  logic [POS_W-1:0]        right_pos,
  output logic                    keep,
  output logic                    occ,         // this slot holds an old candidate after update
  output logic                    valid,
  output logic [SAMPLE_WIDTH-1:0] value,
  output logic [POS_W-1:0]        pos,
  output logic [SAMPLE_WIDTH-1:0] value_next
);
  import swm_pkg::*;

  logic                    take_new;
  logic [SAMPLE_WIDTH-1:0] src_value;
  logic [POS_W-1:0]        src_pos;
  logic [POS_W-1:0]        pos_next;
  logic                    valid_next;

  // equal older candidates survive
  assign keep      = valid && !ctrl.flush && ($signed(value) >= $signed(sample));
  assign occ       = ctrl.shift ? right_keep : keep;
  assign src_value = ctrl.shift ? right_value : value;
  assign src_pos   = ctrl.shift ? right_pos : pos;
  assign take_new  = !occ && left_occ;

  assign value_next = take_new ? sample : src_value;
  assign pos_next   = take_new ? sample_pos : src_pos;
  assign valid_next = occ || take_new;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= value_next;
      pos   <= pos_next;
    end
  end

endmodule
